// File: src/sic_pkg.sv
package sic_pkg;

   localparam int          PASS_FIRST = 21;
   localparam int          PASS_LAST  = 30;
   localparam int          PASS_WIDTH = PASS_LAST - PASS_FIRST + 1;
   localparam logic [31:0] PASS_MASK  = 32'h7fe0_0000;

   typedef enum logic [1:0] {
      FUNC_READ  = 2'd0,
      FUNC_WRITE = 2'd1,
      FUNC_LINE  = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   localparam logic [9:0] REG_STATUS     = 10'd0;
   localparam logic [9:0] REG_RAW        = 10'd1;
   localparam logic [9:0] REG_ENABLE     = 10'd2;
   localparam logic [9:0] REG_ENABLE_CLR = 10'd3;
   localparam logic [9:0] REG_SOFT       = 10'd4;
   localparam logic [9:0] REG_SOFT_CLR   = 10'd5;
   localparam logic [9:0] REG_PASS       = 10'd8;
   localparam logic [9:0] REG_PASS_CLR   = 10'd9;

   typedef struct packed {
      func_type    func;
      logic [9:0]  reg_word;
      logic [31:0] write_data;
      logic [4:0]  line_number;
      logic        line_level;
   } item_type;

   typedef struct packed {
      logic [31:0]           source_levels;
      logic [31:0]           enable_mask;
      logic [31:0]           pass_enable;
      logic [PASS_WIDTH-1:0] pass_levels;
   } state_type;

   typedef struct packed {
      logic [31:0]           read_data;
      logic                  combined_irq;
      logic [PASS_WIDTH-1:0] passed_lines;
      logic                  bad_offset;
   } result_type;

endpackage

// File: src/secondary_interrupt_controller.sv
// Secondary interrupt controller.
// The req_ channel carries one item per transfer: a register read, a register
// write, or a level change on one of 32 source lines. The rsp_ channel returns
// exactly one result per item, in order: read data (0 unless a read), the
// combined request, the ten pass-through line levels and an undefined-offset
// flag.
// An item is captured in the input register, and the register update then
// writes its result into the result register, which drives rsp_. Throughput
// is one item per cycle while rsp_ready stays high, set by the register update
// between the input register and the result register.
// Reset clears the source levels, enable mask, pass-through enables and
// pass-through levels, and empties both register stages.
// When the receiver stalls, the result register holds its result and the
// input register still takes one more item; req_ready drops only once both
// stages are full.
module secondary_interrupt_controller
   import sic_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_func,
   input  logic [9:0]            req_reg_word,
   input  logic [31:0]           req_write_data,
   input  logic [4:0]            req_line_number,
   input  logic                  req_line_level,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [31:0]           rsp_read_data,
   output logic                  rsp_combined_irq,
   output logic [PASS_WIDTH-1:0] rsp_passed_lines,
   output logic                  rsp_bad_offset
);

   logic       in_valid_ff;
   item_type   item_ff;
   state_type  state_ff;
   state_type  state_in;
   logic       rsp_valid_ff;
   result_type result_ff;
   result_type result_in;
   logic       advance;

   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   sic_step u_step (
      .item       (item_ff),
      .state      (state_ff),
      .state_next (state_in),
      .result     (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         if (req_ready) in_valid_ff <= req_valid;
         if (advance) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         item_ff.func        <= func_type'(req_func);
         item_ff.reg_word    <= req_reg_word;
         item_ff.write_data  <= req_write_data;
         item_ff.line_number <= req_line_number;
         item_ff.line_level  <= req_line_level;
      end
      if (advance) result_ff <= result_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = result_ff.read_data;
   assign rsp_combined_irq = result_ff.combined_irq;
   assign rsp_passed_lines = result_ff.passed_lines;
   assign rsp_bad_offset   = result_ff.bad_offset;

endmodule

// File: src/sic_step.sv
module sic_step
   import sic_pkg::*;
(
   input  item_type   item,
   input  state_type  state,
   output state_type  state_next,
   output result_type result
);

   state_type   nxt;
   logic [31:0] rd;
   logic        bad;
   logic        refresh;

   always_comb begin
      nxt     = state;
      rd      = 32'd0;
      bad     = 1'b0;
      refresh = 1'b0;
      case (item.func)
         FUNC_READ: begin
            case (item.reg_word)
               REG_STATUS: rd = state.source_levels & state.enable_mask;
               REG_RAW:    rd = state.source_levels;
               REG_ENABLE: rd = state.enable_mask;
               REG_SOFT:   rd = {31'd0, state.source_levels[0]};
               REG_PASS:   rd = state.pass_enable;
               default:    bad = 1'b1;
            endcase
         end
         FUNC_WRITE: begin
            case (item.reg_word)
               REG_ENABLE:     nxt.enable_mask = state.enable_mask | item.write_data;
               REG_ENABLE_CLR: nxt.enable_mask = state.enable_mask & ~item.write_data;
               REG_SOFT: begin
                  if (item.write_data != 32'd0) nxt.enable_mask[0] = 1'b1;
               end
               REG_SOFT_CLR: begin
                  if (item.write_data != 32'd0) nxt.enable_mask[0] = 1'b0;
               end
               REG_PASS: begin
                  nxt.pass_enable = state.pass_enable | (item.write_data & PASS_MASK);
                  refresh         = 1'b1;
               end
               REG_PASS_CLR: begin
                  nxt.pass_enable = state.pass_enable & ~item.write_data;
                  refresh         = 1'b1;
               end
               default: bad = 1'b1;
            endcase
         end
         FUNC_LINE: begin
            nxt.source_levels[item.line_number] = item.line_level;
            for (int i = 0; i < PASS_WIDTH; i++) begin
               if (item.line_number == 5'(PASS_FIRST + i) && state.pass_enable[PASS_FIRST + i])
                  nxt.pass_levels[i] = item.line_level;
            end
         end
         default: ;
      endcase
      if (refresh) begin
         for (int i = 0; i < PASS_WIDTH; i++) begin
            if (nxt.pass_enable[PASS_FIRST + i])
               nxt.pass_levels[i] = nxt.source_levels[PASS_FIRST + i];
         end
      end
   end

   assign state_next          = nxt;
   assign result.read_data    = rd;
   assign result.combined_irq = |(nxt.source_levels & nxt.enable_mask);
   assign result.passed_lines = nxt.pass_levels;
   assign result.bad_offset   = bad;

endmodule
